// ===== rtl/core/wcg_pkg.sv =====
// shared constants, types and table functions of the window coefficient generator
`timescale 1ns / 1ps

package wcg_pkg;

    // sizing
    localparam int INDEX_BITS     = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int COEF_BITS      = 16;

    localparam int TAB_N       = 1 << COS_TABLE_BITS;
    localparam int ADDR_W      = COS_TABLE_BITS + 1;
    localparam int COS_W       = 31;
    localparam int WGT_W       = 30;
    localparam int PROD_W      = WGT_W + COS_W;
    localparam int SUM_W       = 64;
    localparam int PHASE_W     = 32;
    localparam int WTYPE_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int N_TERMS     = 3;
    localparam int PIPE_DEPTH  = 7;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd4198404;

    // q30 helpers for building the quarter-wave table
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TAYLOR_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

    typedef enum logic [WTYPE_W-1:0] {
        WIN_HANN     = 2'd0,
        WIN_BLACKMAN = 2'd1,
        WIN_HAMMING  = 2'd2,
        WIN_BHARRIS  = 2'd3
    } t_window;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_TYPE = 2'd0,
        REG_PHASE_STEP  = 2'd1
    } t_cfg_reg;

    // one table lookup: magnitude address and cosine sign
    typedef struct packed {
        logic              neg;
        logic [ADDR_W-1:0] addr;
    } t_cos_req;

    // q30 weights of one window
    typedef struct packed {
        logic [WGT_W-1:0] w0;
        logic [WGT_W-1:0] w1;
        logic [WGT_W-1:0] w2;
        logic [WGT_W-1:0] w3;
    } t_wgt_set;

    function automatic t_wgt_set window_weights(input t_window win);
        t_wgt_set w;
        case (win)
            WIN_HANN: begin
                w = '{30'd536870912, 30'd536870912, 30'd0, 30'd0};
            end
            WIN_BLACKMAN: begin
                w = '{30'd450971566, 30'd536870912, 30'd85899346, 30'd0};
            end
            WIN_HAMMING: begin
                w = '{30'd578059648, 30'd495682176, 30'd0, 30'd0};
            end
            WIN_BHARRIS: begin
                w = '{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305};
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/wcg_phase.sv =====
// phase multiply and quarter-wave address generation for the three harmonics
`timescale 1ns / 1ps

module wcg_phase
    import wcg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [INDEX_BITS-1:0]    i_index,
    input  logic [PHASE_W-1:0]       i_step,
    output t_cos_req [N_TERMS-1:0]   o_req
);

    localparam logic [PHASE_W-1:0] ROUND_STEP = PHASE_W'(1) << (29 - COS_TABLE_BITS);
    localparam logic [ADDR_W-1:0]  TAB_TOP    = ADDR_W'(TAB_N);

    logic [INDEX_BITS+PHASE_W-1:0] w_prod;
    logic [PHASE_W-1:0]            r_p1;
    logic [PHASE_W-1:0]            w_ph [N_TERMS];
    logic [PHASE_W-1:0]            w_rp [N_TERMS];
    t_cos_req [N_TERMS-1:0]        n_req;
    t_cos_req [N_TERMS-1:0]        r_req;

    // stage 1: phase of the index, wraps in whole turns
    assign w_prod = (INDEX_BITS+PHASE_W)'(i_index) * (INDEX_BITS+PHASE_W)'(i_step);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= w_prod[PHASE_W-1:0];
        end
    end

    // stage 2: harmonics, rounding to the table step, quadrant folding
    always_comb begin
        w_ph[0] = r_p1;
        w_ph[1] = {r_p1[PHASE_W-2:0], 1'b0};
        w_ph[2] = r_p1 + {r_p1[PHASE_W-2:0], 1'b0};
        for (int j = 0; j < N_TERMS; j++) begin
            w_rp[j] = w_ph[j] + ROUND_STEP;
            // odd quadrants read the table mirrored
            if (w_rp[j][PHASE_W-2]) begin
                n_req[j].addr = TAB_TOP - {1'b0, w_rp[j][PHASE_W-3 -: COS_TABLE_BITS]};
            end else begin
                n_req[j].addr = {1'b0, w_rp[j][PHASE_W-3 -: COS_TABLE_BITS]};
            end
            // cosine is negative in the second and third quadrants
            n_req[j].neg = w_rp[j][PHASE_W-1] ^ w_rp[j][PHASE_W-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

// ===== rtl/core/wcg_cos_rom.sv =====
// quarter-wave cosine rom with one registered read port
`timescale 1ns / 1ps

module wcg_cos_rom
    import wcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [COS_W-1:0]  o_data
);

    logic [COS_W-1:0] w_tab [TAB_N+1];
    logic [COS_W-1:0] r_data;

    // table contents fixed at elaboration, q1.30 from a truncating taylor series
    for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
        localparam longint X  = (HALF_PI_Q30 * longint'(k)) >>> COS_TABLE_BITS;
        localparam longint X2 = (X * X) >>> 30;
        localparam longint T1 = Q30_ONE - (X2 * Q30_ONE) / (TAYLOR_DIV[0] * Q30_ONE);
        localparam longint T2 = Q30_ONE - (X2 * T1) / (TAYLOR_DIV[1] * Q30_ONE);
        localparam longint T3 = Q30_ONE - (X2 * T2) / (TAYLOR_DIV[2] * Q30_ONE);
        localparam longint T4 = Q30_ONE - (X2 * T3) / (TAYLOR_DIV[3] * Q30_ONE);
        localparam longint T5 = Q30_ONE - (X2 * T4) / (TAYLOR_DIV[4] * Q30_ONE);
        localparam longint T6 = Q30_ONE - (X2 * T5) / (TAYLOR_DIV[5] * Q30_ONE);
        localparam longint T7 = Q30_ONE - (X2 * T6) / (TAYLOR_DIV[6] * Q30_ONE);
        // clamp to [0, 1.0], exact end points
        localparam longint TC = (T7 < 0) ? 64'sd0 : ((T7 > Q30_ONE) ? Q30_ONE : T7);
        localparam logic [COS_W-1:0] ENTRY = (k == 0) ? COS_W'(Q30_ONE)
                                           : ((k == TAB_N) ? COS_W'(0) : COS_W'(TC));
        assign w_tab[k] = ENTRY;
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/wcg_combine.sv =====
// weighting, summing, rounding and saturation of the cosine terms
`timescale 1ns / 1ps

module wcg_combine
    import wcg_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_en,
    input  t_window                         i_window,
    input  logic [N_TERMS-1:0][COS_W-1:0]   i_mag,
    input  logic [N_TERMS-1:0]              i_neg,
    output logic [COEF_BITS-1:0]            o_coefficient
);

    localparam int                       RES_SHIFT  = 61 - COEF_BITS;
    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (60 - COEF_BITS);
    localparam logic signed [SUM_W-1:0]  ONE_WIDE   = SUM_W'(1) << (COEF_BITS - 1);
    localparam logic [COEF_BITS-1:0]     COEF_ONE   = COEF_BITS'(1) << (COEF_BITS - 1);

    t_wgt_set                  w_wgt;
    logic [PROD_W-1:0]         r4_base;
    logic [PROD_W-1:0]         r4_prod [N_TERMS];
    logic [N_TERMS-1:0]        r4_neg;
    logic signed [SUM_W-1:0]   w_term [N_TERMS];
    logic signed [SUM_W-1:0]   r5_t1;
    logic signed [SUM_W-1:0]   r5_t2;
    logic signed [SUM_W-1:0]   r6_sum;
    logic signed [SUM_W-1:0]   w_round;
    logic [COEF_BITS-1:0]      n_coef;
    logic [COEF_BITS-1:0]      r_coef;

    assign w_wgt = window_weights(i_window);

    // stage 4: one multiplier per harmonic
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_base    <= PROD_W'(w_wgt.w0) << 30;
            r4_prod[0] <= PROD_W'(w_wgt.w1) * PROD_W'(i_mag[0]);
            r4_prod[1] <= PROD_W'(w_wgt.w2) * PROD_W'(i_mag[1]);
            r4_prod[2] <= PROD_W'(w_wgt.w3) * PROD_W'(i_mag[2]);
            r4_neg     <= i_neg;
        end
    end

    // stage 5: signed partial sums, odd harmonics enter subtracted
    always_comb begin
        for (int j = 0; j < N_TERMS; j++) begin
            w_term[j] = $signed(SUM_W'(r4_prod[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_t1 <= $signed(SUM_W'(r4_base)) + (r4_neg[0] ? w_term[0] : -w_term[0]);
            r5_t2 <= (r4_neg[1] ? -w_term[1] : w_term[1])
                   + (r4_neg[2] ? w_term[2] : -w_term[2]);
        end
    end

    // stage 6: full sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_sum <= r5_t1 + r5_t2;
        end
    end

    // stage 7: round to output precision, clamp to [0, 1.0]
    assign w_round = (r6_sum + ROUND_HALF) >>> RES_SHIFT;

    always_comb begin
        if (r6_sum <= 0) begin
            n_coef = '0;
        end else if (w_round > ONE_WIDE) begin
            n_coef = COEF_ONE;
        end else begin
            n_coef = w_round[COEF_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= n_coef;
        end
    end

    assign o_coefficient = r_coef;

endmodule

// ===== rtl/core/window_coefficient_generator.sv =====
// top level of the spectral window coefficient generator
`timescale 1ns / 1ps

// Returns one Hann, Blackman, Hamming or 4-term Blackman-Harris coefficient
// (unsigned Q1.15, 32768 = 1.0) per sample index, one beat per clock
// sustained while the output is not stalled. The pipeline has seven register
// stages: phase multiply, address folding, quarter-wave rom read (three rom
// copies, one per harmonic), weight multiply, two adder stages and
// round/saturate. Phase is index times phase_step, which software sets to
// 2^32/(length-1). A stall on a valid output beat freezes the whole pipeline
// and the input stall follows it in the same cycle. Registers are to be
// written only while the block is idle, which the block itself does not
// enforce; they act on the next beat accepted.

module window_coefficient_generator
    import wcg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INDEX_BITS-1:0]   i_sample_index,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [COEF_BITS-1:0]    o_coefficient
);

    t_window                        r_window_type;
    logic [PHASE_W-1:0]             r_phase_step;
    logic [PIPE_DEPTH:1]            r_vld;
    logic                           w_en;
    logic                           w_accept;
    t_cos_req [N_TERMS-1:0]         w_req;
    logic [N_TERMS-1:0][COS_W-1:0]  w_mag;
    logic [N_TERMS-1:0]             r3_neg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_type <= WIN_HANN;
            r_phase_step  <= PHASE_STEP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_WINDOW_TYPE: r_window_type <= t_window'(i_cfg_data[WTYPE_W-1:0]);
                REG_PHASE_STEP:  r_phase_step  <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the last stage holds a beat that is stalled
    assign w_en     = !(r_vld[PIPE_DEPTH] && i_stall);
    assign w_accept = i_valid && w_en;
    assign o_stall  = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-1:1], w_accept};
        end
    end

    // stages 1-2
    wcg_phase u_phase (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_index (i_sample_index),
        .i_step  (r_phase_step),
        .o_req   (w_req)
    );

    // stage 3: one rom per harmonic
    for (genvar j = 0; j < N_TERMS; j++) begin : g_rom
        wcg_cos_rom u_rom (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_addr (w_req[j].addr),
            .o_data (w_mag[j])
        );
    end

    // sign flags ride alongside the rom read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < N_TERMS; j++) begin
                r3_neg[j] <= w_req[j].neg;
            end
        end
    end

    // stages 4-7
    wcg_combine u_combine (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_window      (r_window_type),
        .i_mag         (w_mag),
        .i_neg         (r3_neg),
        .o_coefficient (o_coefficient)
    );

    assign o_valid = r_vld[PIPE_DEPTH];

`ifndef ASSERT_OFF
    // input stall only ever comes from a held output beat
    a_stall_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    // an accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld[1])
        else $error("accepted beat lost at stage one");

    // a frozen pipeline keeps its valid pattern
    a_freeze_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_vld == $past(r_vld)))
        else $error("valid bits moved while pipeline frozen");

    // saturation keeps the result within one
    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coefficient <= (COEF_BITS'(1) << (COEF_BITS - 1))))
        else $error("coefficient above one");
`endif

endmodule
